// ----- rtl/core/nas_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nas_pkg
// Shared types and constants for the nonlinear advection stencil.
// ----------------------------------------------------------------------------
package nas_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 12;
    localparam int COEF_W   = 24;
    localparam int DIFF_W   = 17;
    localparam int P1_W     = 27;
    localparam int P2_W     = 33;
    localparam int PROD_W   = 60;
    localparam int TERM_W   = 35;
    localparam int SUM_W    = 36;

    // speed after reset: 1.0 in Q4.12
    localparam logic signed [SAMPLE_W-1:0] SPEED_RESET = 16'sd4096;

    // coefficient build constants
    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned RCP_MAX = 64'd8388607;

    // saturation bounds of a Q4.12 result
    localparam logic signed [SUM_W-1:0] SAT_HI = 36'sd32767;
    localparam logic signed [SUM_W-1:0] SAT_LO = -36'sd32768;

    // operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MUL_COEF,
        MUL_DIFF,
        MUL_TERM
    } mul_op_t;

    typedef struct packed {
        logic    en;
        mul_op_t op;
    } mul_ctrl_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL_P1,
        ST_MUL_P2,
        ST_MUL_TERM,
        ST_ROUND,
        ST_WRITE
    } seq_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/nas_coef_rom.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nas_coef_rom
// Reciprocal sine grid factors in unsigned Q10.14, built at elaboration
// from the field length, with a registered read port.
// ----------------------------------------------------------------------------
module nas_coef_rom #(
    parameter int POINTS = 64,
    parameter int AW     = 6
) (
    input  wire logic                           clk,
    input  wire logic [AW-1:0]                  addr,
    output logic      [nas_pkg::COEF_W-1:0]     coef
);

    logic [nas_pkg::COEF_W-1:0] coef_table [POINTS];
    logic [nas_pkg::COEF_W-1:0] coef_reg;

    // one entry per grid point: Taylor sine in Q30, then rounded reciprocal
    for (genvar gi = 0; gi < POINTS; gi++) begin : g_coef
        localparam longint unsigned M  = 64'(2 * (POINTS - 1));
        localparam longint unsigned K0 = (gi == 0 || gi == POINTS - 1) ? 64'd1
                                         : 64'(2 * (POINTS - 1 - gi));
        localparam longint unsigned K  = (2 * K0 > M) ? (M - K0) : K0;
        localparam longint unsigned X  = (K * nas_pkg::PI_Q30 + M / 2) / M;
        localparam longint unsigned X2 = (X * X) >> 30;
        localparam longint unsigned T1 = ((X  * X2) >> 30) / 6;
        localparam longint unsigned T2 = ((T1 * X2) >> 30) / 20;
        localparam longint unsigned T3 = ((T2 * X2) >> 30) / 42;
        localparam longint unsigned T4 = ((T3 * X2) >> 30) / 72;
        localparam longint unsigned T5 = ((T4 * X2) >> 30) / 110;
        localparam longint unsigned T6 = ((T5 * X2) >> 30) / 156;
        localparam longint unsigned T7 = ((T6 * X2) >> 30) / 210;
        localparam longint S  = longint'(X) - longint'(T1) + longint'(T2)
                                - longint'(T3) + longint'(T4) - longint'(T5)
                                + longint'(T6) - longint'(T7);
        localparam longint unsigned SD = (S <= 0) ? 64'd1 : 64'(S);
        localparam longint unsigned RQ = ((64'd1 << 44) + SD / 2) / SD;
        localparam longint unsigned RS = (S <= 0 || RQ > nas_pkg::RCP_MAX)
                                         ? nas_pkg::RCP_MAX : RQ;

        assign coef_table[gi] = RS[nas_pkg::COEF_W-1:0];
    end

    // registered read
    always_ff @(posedge clk)
    begin
        coef_reg <= coef_table[addr];
    end

    assign coef = coef_reg;

endmodule
`default_nettype wire

// ----- rtl/core/nas_mul_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nas_mul_unit
// Shared signed multiplier with operand select and registered product;
// serves the coefficient, difference and term products in turn.
// ----------------------------------------------------------------------------
module nas_mul_unit (
    input  wire logic                                    clk,
    input  wire nas_pkg::mul_ctrl_t                      ctrl,
    input  wire logic signed [nas_pkg::SAMPLE_W-1:0]     speed,
    input  wire logic        [nas_pkg::COEF_W-1:0]       coef,
    input  wire logic signed [nas_pkg::DIFF_W-1:0]       diff,
    input  wire logic signed [nas_pkg::SAMPLE_W-1:0]     field,
    input  wire logic signed [nas_pkg::P1_W-1:0]         p1,
    output logic      signed [nas_pkg::PROD_W-1:0]       product
);

    logic signed [nas_pkg::PROD_W-1:0] prod_reg;
    logic signed [nas_pkg::DIFF_W-1:0] neg_speed;
    logic signed [nas_pkg::P1_W-1:0]   op_a;
    logic signed [nas_pkg::P2_W-1:0]   op_b;

    // -speed fits 17 bits, including the most negative code
    assign neg_speed = -$signed({speed[nas_pkg::SAMPLE_W-1], speed});

    // operand select
    always_comb
    begin
        case (ctrl.op)
            nas_pkg::MUL_COEF:
            begin
                op_a = nas_pkg::P1_W'(neg_speed);
                op_b = $signed({{(nas_pkg::P2_W-nas_pkg::COEF_W){1'b0}}, coef});
            end
            nas_pkg::MUL_DIFF:
            begin
                op_a = nas_pkg::P1_W'(diff);
                op_b = nas_pkg::P2_W'(field);
            end
            nas_pkg::MUL_TERM:
            begin
                op_a = p1;
                op_b = prod_reg[nas_pkg::P2_W-1:0];
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // product register
    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign product = prod_reg;

endmodule
`default_nettype wire

// ----- rtl/core/nonlinear_advection_stencil.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nonlinear_advection_stencil
// Adds the advection term -c/fac[i]*d*u[i] to the prior value of each grid
// point of a streamed 1-D field, using one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request per grid point, carrying
//   the sample u and the prior output at that point. A field is POINTS
//   requests long; the request after the last one starts a new field.
//   Output channel (out_valid / out_stall): updated_value, point_index, last.
//   Results lag the input by one point: the first request of a field gives
//   nothing, the final one gives two results (the second with last set).
//   Configuration: cfg_we writes cfg_wdata into speed (signed Q4.12); write
//   only while the block is idle.
//   Sequence: each result passes FETCH (ROM read), MUL_P1, MUL_P2 and
//   MUL_TERM (three chained products on the shared multiplier), ROUND
//   and WRITE (saturating add); a request that gives no result is taken
//   in IDLE alone. in_stall is high while a request is being worked on.
//   A finished result sits in the output register; a stalled receiver holds
//   it there and the sequencer waits only when the next result is ready.
//   Reset clears the window, the point counter and the output valid, and
//   sets speed to 1.0.
// ----------------------------------------------------------------------------
module nonlinear_advection_stencil #(
    parameter int POINTS = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // input channel
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [nas_pkg::SAMPLE_W-1:0]    sample,
    input  wire logic signed [nas_pkg::SAMPLE_W-1:0]    prior_value,
    // output channel
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic      signed [nas_pkg::SAMPLE_W-1:0]    updated_value,
    output logic             [nas_pkg::INDEX_W-1:0]     point_index,
    output logic                                        last,
    // configuration
    input  wire logic                                   cfg_we,
    input  wire logic signed [nas_pkg::SAMPLE_W-1:0]    cfg_wdata
);

    localparam int CW = $clog2(POINTS);
    localparam logic [CW-1:0] LAST_IDX = CW'(POINTS - 1);

    // sequencer
    nas_pkg::seq_state_t state_reg, state_next;
    nas_pkg::mul_ctrl_t  mul_ctrl;
    logic accept;
    logic load_p1;
    logic load_term;
    logic out_load;
    logic out_free;

    // control registers
    logic signed [nas_pkg::SAMPLE_W-1:0] speed_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          out_valid_reg, out_valid_next;

    // window and job payload
    logic signed [nas_pkg::SAMPLE_W-1:0] win0_reg, win1_reg, prior1_reg;
    logic signed [nas_pkg::DIFF_W-1:0]   job_d_reg;
    logic signed [nas_pkg::SAMPLE_W-1:0] job_u_reg, job_prior_reg;
    logic                                job_half_reg, job_last_reg;
    logic [CW-1:0]                       addr_reg;
    logic signed [nas_pkg::DIFF_W-1:0]   pend_d_reg;
    logic signed [nas_pkg::SAMPLE_W-1:0] pend_u_reg, pend_prior_reg;

    // arithmetic
    logic        [nas_pkg::COEF_W-1:0]   coef;
    logic signed [nas_pkg::PROD_W-1:0]   product;
    logic signed [nas_pkg::P1_W-1:0]     p1_reg;
    logic signed [nas_pkg::TERM_W-1:0]   term_reg;
    logic signed [nas_pkg::PROD_W-1:0]   rnd_half, rnd_full;
    logic signed [nas_pkg::PROD_W-1:0]   rnd_p1;
    logic signed [nas_pkg::SUM_W-1:0]    sum;
    logic signed [nas_pkg::SAMPLE_W-1:0] sat_value;

    // output register
    logic signed [nas_pkg::SAMPLE_W-1:0] out_value_reg;
    logic [CW-1:0]                       out_idx_reg;
    logic                                out_last_reg;

    // accept-time job decode
    logic                                has_a, has_b;
    logic signed [nas_pkg::DIFF_W-1:0]   cur_ext;
    logic signed [nas_pkg::DIFF_W-1:0]   d_a, d_b;

    assign cur_ext = nas_pkg::DIFF_W'(sample);
    assign has_a   = (count_reg != '0);
    assign has_b   = (count_reg >= LAST_IDX);
    assign d_a     = cur_ext - ((count_reg == CW'(1)) ? nas_pkg::DIFF_W'(win1_reg)
                                                     : nas_pkg::DIFF_W'(win0_reg));
    assign d_b     = cur_ext - nas_pkg::DIFF_W'(win1_reg);
    assign out_free = !out_valid_reg || !out_stall;

    // coefficient table
    nas_coef_rom #(
        .POINTS (POINTS),
        .AW     (CW)
    ) u_coef_rom (
        .clk  (clk),
        .addr (addr_reg),
        .coef (coef)
    );

    // shared multiplier
    nas_mul_unit u_mul_unit (
        .clk     (clk),
        .ctrl    (mul_ctrl),
        .speed   (speed_reg),
        .coef    (coef),
        .diff    (job_d_reg),
        .field   (job_u_reg),
        .p1      (p1_reg),
        .product (product)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nas_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and sequencer outputs
    always_comb
    begin
        state_next  = state_reg;
        accept      = 1'b0;
        load_p1     = 1'b0;
        load_term   = 1'b0;
        out_load    = 1'b0;
        mul_ctrl.en = 1'b0;
        mul_ctrl.op = nas_pkg::MUL_COEF;
        case (state_reg)
            nas_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    accept = 1'b1;
                    if (has_a || has_b)
                    begin
                        state_next = nas_pkg::ST_FETCH;
                    end
                end
            end
            nas_pkg::ST_FETCH:
            begin
                state_next = nas_pkg::ST_MUL_P1;
            end
            nas_pkg::ST_MUL_P1:
            begin
                mul_ctrl.en = 1'b1;
                mul_ctrl.op = nas_pkg::MUL_COEF;
                state_next  = nas_pkg::ST_MUL_P2;
            end
            nas_pkg::ST_MUL_P2:
            begin
                mul_ctrl.en = 1'b1;
                mul_ctrl.op = nas_pkg::MUL_DIFF;
                load_p1     = 1'b1;
                state_next  = nas_pkg::ST_MUL_TERM;
            end
            nas_pkg::ST_MUL_TERM:
            begin
                mul_ctrl.en = 1'b1;
                mul_ctrl.op = nas_pkg::MUL_TERM;
                state_next  = nas_pkg::ST_ROUND;
            end
            nas_pkg::ST_ROUND:
            begin
                load_term  = 1'b1;
                state_next = nas_pkg::ST_WRITE;
            end
            nas_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = pend_valid_reg ? nas_pkg::ST_FETCH : nas_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nas_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != nas_pkg::ST_IDLE);

    // speed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= nas_pkg::SPEED_RESET;
        end
        else if (cfg_we)
        begin
            speed_reg <= cfg_wdata;
        end
    end

    // point counter and pending second result
    always_comb
    begin
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        if (accept)
        begin
            count_next      = has_b ? '0 : count_reg + CW'(1);
            pend_valid_next = has_a && has_b;
        end
        else if (out_load && pend_valid_reg)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            win0_reg       <= '0;
            win1_reg       <= '0;
            prior1_reg     <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            if (accept)
            begin
                win0_reg   <= win1_reg;
                win1_reg   <= sample;
                prior1_reg <= prior_value;
            end
        end
    end

    // job operands: interior or left-end job first, right-end job queued
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (has_a)
            begin
                job_d_reg     <= d_a;
                job_u_reg     <= win1_reg;
                job_prior_reg <= prior1_reg;
                job_half_reg  <= (count_reg != CW'(1));
                job_last_reg  <= 1'b0;
                addr_reg      <= count_reg - CW'(1);
            end
            else
            begin
                job_d_reg     <= d_b;
                job_u_reg     <= sample;
                job_prior_reg <= prior_value;
                job_half_reg  <= 1'b0;
                job_last_reg  <= 1'b1;
                addr_reg      <= LAST_IDX;
            end
            pend_d_reg     <= d_b;
            pend_u_reg     <= sample;
            pend_prior_reg <= prior_value;
        end
        else if (out_load && pend_valid_reg)
        begin
            job_d_reg     <= pend_d_reg;
            job_u_reg     <= pend_u_reg;
            job_prior_reg <= pend_prior_reg;
            job_half_reg  <= 1'b0;
            job_last_reg  <= 1'b1;
            addr_reg      <= LAST_IDX;
        end
    end

    // rounding of the products, half up
    assign rnd_p1   = (product + nas_pkg::PROD_W'(64'sd8192)) >>> 14;
    assign rnd_full = (product + nas_pkg::PROD_W'(64'sd8388608)) >>> 24;
    assign rnd_half = (product + nas_pkg::PROD_W'(64'sd16777216)) >>> 25;

    always_ff @(posedge clk)
    begin
        if (load_p1)
        begin
            p1_reg <= rnd_p1[nas_pkg::P1_W-1:0];
        end
        if (load_term)
        begin
            term_reg <= job_half_reg ? rnd_half[nas_pkg::TERM_W-1:0]
                                     : rnd_full[nas_pkg::TERM_W-1:0];
        end
    end

    // saturating add with the prior value
    assign sum = nas_pkg::SUM_W'(job_prior_reg) + nas_pkg::SUM_W'(term_reg);

    always_comb
    begin
        if (sum > nas_pkg::SAT_HI)
        begin
            sat_value = nas_pkg::SAT_HI[nas_pkg::SAMPLE_W-1:0];
        end
        else if (sum < nas_pkg::SAT_LO)
        begin
            sat_value = nas_pkg::SAT_LO[nas_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            sat_value = sum[nas_pkg::SAMPLE_W-1:0];
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= sat_value;
            out_idx_reg   <= addr_reg;
            out_last_reg  <= job_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign updated_value = out_value_reg;
    assign point_index   = nas_pkg::INDEX_W'(out_idx_reg);
    assign last          = out_last_reg;

endmodule
`default_nettype wire
